>>> src/cpp_source_tokenizer_assert.svh
`ifndef CPP_SOURCE_TOKENIZER_ASSERT_SVH
`define CPP_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cst_pkg.sv
package cst_pkg;

  localparam int unsigned LineBitsDef = 24;
  localparam int unsigned TokLineW    = 24;
  localparam int unsigned MaxRes      = 3;
  localparam int unsigned ResCntW     = $clog2(MaxRes + 1);

  typedef enum logic [2:0] {
    TK_STR   = 3'd0,
    TK_CHR   = 3'd1,
    TK_NUM   = 3'd2,
    TK_IDENT = 3'd3,
    TK_SCOPE = 3'd4,
    TK_PUNCT = 3'd5,
    TK_EOF   = 3'd6
  } tok_kind_e;

  typedef enum logic [2:0] {
    LM_IDLE  = 3'd0,
    LM_PP    = 3'd1,
    LM_LCOM  = 3'd2,
    LM_BCOM  = 3'd3,
    LM_STR   = 3'd4,
    LM_CHR   = 3'd5,
    LM_NUM   = 3'd6,
    LM_IDENT = 3'd7
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       byte_present;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          token_kind;
    logic [7:0]          text_byte;
    logic                first_of_token;
    logic [TokLineW-1:0] token_line;
    logic                last_of_run;
  } out_word_t;

  // results of one step: count plus the words in order
  typedef struct packed {
    logic [ResCntW-1:0]       n;
    out_word_t [MaxRes-1:0]   word;
  } res_set_t;

endpackage

>>> src/cst_lex_core.sv
module cst_lex_core import cst_pkg::*; #(
  parameter int unsigned LineBits = LineBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t word_i,
  input  logic     step_i,
  output res_set_t set_o
);

  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDot    = 8'h2E;

  lex_mode_e           mode_q, mode_d;
  logic [7:0]          la_byte_q, la_byte_d;
  logic                la_valid_q, la_valid_d;
  logic [LineBits-1:0] line_q, line_d;
  logic [LineBits-1:0] start_q, start_d;
  logic                at_ls_q, at_ls_d;
  logic                esc_q, esc_d;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // saturating line increment
  function automatic logic [LineBits-1:0] bump(input logic [LineBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic out_word_t mk(input tok_kind_e k, input logic [7:0] c,
                                   input logic first, input logic [LineBits-1:0] ln);
    out_word_t w;
    w.token_kind     = k;
    w.text_byte      = c;
    w.first_of_token = first;
    w.token_line     = TokLineW'(ln);
    w.last_of_run    = 1'b0;
    return w;
  endfunction

  always_comb begin : step
    logic [7:0]         b;
    logic [7:0]         h;
    logic               run_idle;
    logic               skip;
    logic [ResCntW-1:0] n;
    res_set_t           set;

    b          = word_i.src_byte;
    h          = la_byte_q;
    run_idle   = 1'b0;
    skip       = 1'b0;
    n          = '0;
    set        = '0;
    mode_d     = mode_q;
    la_byte_d  = la_byte_q;
    la_valid_d = la_valid_q;
    line_d     = line_q;
    start_d    = start_q;
    at_ls_d    = at_ls_q;
    esc_d      = esc_q;

    if (word_i.byte_present) begin
      case (mode_q)
        LM_PP: begin
          if (b == ChNl) begin
            if (esc_q) begin
              line_d = bump(line_d);
              esc_d  = 1'b0;
            end else begin
              mode_d   = LM_IDLE;
              run_idle = 1'b1;
            end
          end else begin
            esc_d = (b == ChBslash);
          end
        end
        LM_LCOM: begin
          if (b == ChNl) begin
            mode_d   = LM_IDLE;
            run_idle = 1'b1;
          end
        end
        LM_BCOM: begin
          // a newline is counted only once a further byte arrives
          if (la_valid_q) begin
            line_d     = bump(line_d);
            la_valid_d = 1'b0;
            la_byte_d  = '0;
          end
          if (esc_q && b == ChSlash) begin
            mode_d = LM_IDLE;
            esc_d  = 1'b0;
          end else if (b == ChNl) begin
            la_valid_d = 1'b1;
            la_byte_d  = ChNl;
            esc_d      = 1'b0;
          end else begin
            esc_d = (b == ChStar);
          end
        end
        LM_STR, LM_CHR: begin
          set.word[n] = mk((mode_q == LM_STR) ? TK_STR : TK_CHR, b, 1'b0, start_q);
          n = n + 1'b1;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (b == ChBslash) begin
            esc_d = 1'b1;
          end else if (b == ((mode_q == LM_STR) ? ChDquote : ChSquote)) begin
            mode_d = LM_IDLE;
          end else if (b == ChNl && mode_q == LM_STR) begin
            line_d = bump(line_d);
          end
        end
        LM_NUM: begin
          if (is_digit(b) || is_alpha(b) || b == ChDot || b == ChSquote) begin
            set.word[n] = mk(TK_NUM, b, 1'b0, start_q);
            n = n + 1'b1;
          end else begin
            mode_d   = LM_IDLE;
            run_idle = 1'b1;
          end
        end
        LM_IDENT: begin
          if (is_digit(b) || is_alpha(b) || b == ChUnder) begin
            set.word[n] = mk(TK_IDENT, b, 1'b0, start_q);
            n = n + 1'b1;
          end else begin
            mode_d   = LM_IDLE;
            run_idle = 1'b1;
          end
        end
        default: begin
          mode_d   = LM_IDLE;
          run_idle = 1'b1;
        end
      endcase
    end

    if (run_idle) begin
      if (la_valid_d) begin
        h          = la_byte_d;
        la_valid_d = 1'b0;
        la_byte_d  = '0;
        if (h == ChColon && b == ChColon) begin
          set.word[n] = mk(TK_SCOPE, ChColon, 1'b1, start_d);
          n = n + 1'b1;
          set.word[n] = mk(TK_SCOPE, ChColon, 1'b0, start_d);
          n = n + 1'b1;
          skip = 1'b1;
        end else if (h == ChSlash && b == ChSlash) begin
          mode_d = LM_LCOM;
          skip   = 1'b1;
        end else if (h == ChSlash && b == ChStar) begin
          mode_d = LM_BCOM;
          esc_d  = 1'b0;
          skip   = 1'b1;
        end else begin
          set.word[n] = mk(TK_PUNCT, h, 1'b1, start_d);
          n = n + 1'b1;
        end
      end
      if (!skip) begin
        if (b == ChNl) begin
          line_d  = bump(line_d);
          at_ls_d = 1'b1;
        end else if (is_space(b)) begin
          at_ls_d = at_ls_d;
        end else if (b == ChHash && at_ls_d) begin
          mode_d = LM_PP;
          esc_d  = 1'b0;
        end else begin
          at_ls_d = 1'b0;
          start_d = line_d;
          if (b == ChSlash || b == ChColon) begin
            la_byte_d  = b;
            la_valid_d = 1'b1;
          end else if (b == ChDquote) begin
            set.word[n] = mk(TK_STR, b, 1'b1, line_d);
            n = n + 1'b1;
            mode_d = LM_STR;
            esc_d  = 1'b0;
          end else if (b == ChSquote) begin
            set.word[n] = mk(TK_CHR, b, 1'b1, line_d);
            n = n + 1'b1;
            mode_d = LM_CHR;
            esc_d  = 1'b0;
          end else if (is_digit(b)) begin
            set.word[n] = mk(TK_NUM, b, 1'b1, line_d);
            n = n + 1'b1;
            mode_d = LM_NUM;
            esc_d  = 1'b0;
          end else if (is_alpha(b) || b == ChUnder) begin
            set.word[n] = mk(TK_IDENT, b, 1'b1, line_d);
            n = n + 1'b1;
            mode_d = LM_IDENT;
            esc_d  = 1'b0;
          end else begin
            set.word[n] = mk(TK_PUNCT, b, 1'b1, line_d);
            n = n + 1'b1;
          end
        end
      end
    end

    if (word_i.end_of_source) begin
      // a held '/' or ':' goes out as punctuation
      if (mode_d == LM_IDLE && la_valid_d) begin
        set.word[n] = mk(TK_PUNCT, la_byte_d, 1'b1, start_d);
        n = n + 1'b1;
      end
      set.word[n] = mk(TK_EOF, 8'h00, 1'b1, line_d);
      n = n + 1'b1;
      mode_d     = LM_IDLE;
      la_byte_d  = '0;
      la_valid_d = 1'b0;
      line_d     = LineBits'(1);
      start_d    = LineBits'(1);
      at_ls_d    = 1'b1;
      esc_d      = 1'b0;
    end

    for (int i = 0; i < MaxRes; i++) begin
      set.word[i].last_of_run = (n == ResCntW'(i + 1));
    end
    set.n = n;
    set_o = set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= LM_IDLE;
      la_byte_q  <= '0;
      la_valid_q <= 1'b0;
      line_q     <= LineBits'(1);
      start_q    <= LineBits'(1);
      at_ls_q    <= 1'b1;
      esc_q      <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      la_byte_q  <= la_byte_d;
      la_valid_q <= la_valid_d;
      line_q     <= line_d;
      start_q    <= start_d;
      at_ls_q    <= at_ls_d;
      esc_q      <= esc_d;
    end
  end

endmodule

>>> src/cst_res_queue.sv
module cst_res_queue import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_set_t  set_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  out_word_t [MaxRes-1:0] slot_q, slot_d;
  logic [ResCntW-1:0]     cnt_q, cnt_d;
  logic                   drain;

  assign drain       = (cnt_q != '0) && out_ready_i;
  // room for a fresh set once the last held word leaves this cycle
  assign free_o      = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_ready_i);
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = slot_q[0];

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d = set_i.word;
      cnt_d  = set_i.n;
    end else if (drain) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

>>> src/cpp_source_tokenizer.sv
// Streaming C++ lexer, one source byte per input word.
// Input channel (in_valid_i/in_ready_o, in_word_i): src_byte, byte_present,
// end_of_source. A word with byte_present low and end_of_source high just
// closes the source. Output channel (out_valid_o/out_ready_i, out_word_o):
// one kept byte per word, tagged with token kind, first-of-token, the
// token's start line and last_of_run on the final word caused by an input.
// Each input word gives zero to three output words; end_of_source adds an
// end-of-file word and returns the lexer to line 1.
// Path: an accepted input word is held in the input register; its step's
// words are registered in the result buffer, which drives the output.
// Throughput: one input word per cycle while each gives at most one output
// word and out_ready_i is high; otherwise bounded by the output, one word per
// cycle, as the result buffer drains a step's words before loading the next.
// Stall: the result buffer holds while out_ready_i is low; the input
// register holds one more word, then in_ready_o drops.
// Reset: asynchronous, active low; lexer idle at line 1, buffers empty.
`include "cpp_source_tokenizer_assert.svh"

module cpp_source_tokenizer import cst_pkg::*; #(
  parameter int unsigned LineBits = LineBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  in_word_t in_q;
  logic     in_v_q;
  res_set_t set;
  logic     q_free;
  logic     fire;

  // a step with no results never waits for the buffer
  assign fire       = in_v_q && ((set.n == '0) || q_free);
  assign in_ready_o = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  cst_lex_core #(
    .LineBits(LineBits)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .word_i(in_q),
    .step_i(fire),
    .set_o (set)
  );

  cst_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && (set.n != '0)),
    .set_i      (set),
    .free_o     (q_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  `CST_ASSERT_IMP(a_eof_last, out_valid_o && out_word_o.token_kind == TK_EOF,
    out_word_o.last_of_run && out_word_o.first_of_token && out_word_o.text_byte == 8'h00,
    "end-of-file word malformed")
  `CST_ASSERT_NXT(a_run_cont, out_valid_o && out_ready_i && !out_word_o.last_of_run,
    out_valid_o, "run broken before its last word")
  `CST_ASSERT_NXT(a_in_hold, in_v_q && !fire, in_v_q && $stable(in_q),
    "held input word lost")
  `CST_ASSERT_IMP(a_step_room, fire && set.n != '0, q_free, "step loaded into busy buffer")

endmodule

>>> tb/cpp_source_tokenizer_test.sv
`timescale 1ns / 100ps

module cpp_source_tokenizer_test;
  import cst_pkg::*;

  // narrow line counter; token_line is wider than the count
  localparam int unsigned LINE_BITS_TB = 8;
  localparam int unsigned RAND_ITEMS   = 85;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_PRINTS   = 40;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = " ";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_US    = "_";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_BSL   = "\\";
  localparam logic [7:0] CH_DQ    = "\"";
  localparam logic [7:0] CH_SQ    = "'";
  localparam logic [7:0] CH_DOT   = ".";

  class lexer_scoreboard;
    lex_mode_e       mode;
    logic [7:0]      held;
    bit              held_v;      // in block comments: a newline waiting to be counted
    longint unsigned line_no;
    longint unsigned tok_line;
    bit              line_start;
    bit              esc_star;
    longint unsigned line_max;
    out_word_t       step_q[$];
    out_word_t       expected_q[$];
    int unsigned     errors;

    function new(int unsigned line_bits);
      line_max = (64'd1 << line_bits) - 64'd1;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      mode       = LM_IDLE;
      held       = 8'h00;
      held_v     = 1'b0;
      line_no    = 1;
      tok_line   = 1;
      line_start = 1'b1;
      esc_star   = 1'b0;
    endfunction

    function void bump();
      if (line_no < line_max) line_no++;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_alnum(logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SP || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function void push_tok(tok_kind_e k, logic [7:0] b, bit first, longint unsigned ln);
      out_word_t w;
      if (step_q.size() >= MaxRes) return;
      w.token_kind     = k;
      w.text_byte      = b;
      w.first_of_token = first;
      w.token_line     = ln[TokLineW-1:0];
      w.last_of_run    = 1'b0;
      step_q = {step_q, w};
    endfunction

    function void open_token(lex_mode_e m, tok_kind_e k, logic [7:0] b);
      tok_line = line_no;
      push_tok(k, b, 1'b1, tok_line);
      mode     = m;
      esc_star = 1'b0;
    endfunction

    function void between_tokens(logic [7:0] b);
      logic [7:0] h;
      if (held_v) begin
        h      = held;
        held_v = 1'b0;
        held   = 8'h00;
        if (h == CH_COLON && b == CH_COLON) begin
          push_tok(TK_SCOPE, CH_COLON, 1'b1, tok_line);
          push_tok(TK_SCOPE, CH_COLON, 1'b0, tok_line);
          return;
        end
        if (h == CH_SLASH && b == CH_SLASH) begin
          mode = LM_LCOM;
          return;
        end
        if (h == CH_SLASH && b == CH_STAR) begin
          mode     = LM_BCOM;
          esc_star = 1'b0;
          return;
        end
        push_tok(TK_PUNCT, h, 1'b1, tok_line);
      end
      if (b == CH_NL) begin
        bump();
        line_start = 1'b1;
        return;
      end
      if (is_blank(b)) return;
      if (b == CH_HASH && line_start) begin
        mode     = LM_PP;
        esc_star = 1'b0;
        return;
      end
      line_start = 1'b0;
      if (b == CH_SLASH || b == CH_COLON) begin
        held     = b;
        held_v   = 1'b1;
        tok_line = line_no;
      end else if (b == CH_DQ) begin
        open_token(LM_STR, TK_STR, b);
      end else if (b == CH_SQ) begin
        open_token(LM_CHR, TK_CHR, b);
      end else if (is_digit(b)) begin
        open_token(LM_NUM, TK_NUM, b);
      end else if (is_alnum(b) || b == CH_US) begin
        open_token(LM_IDENT, TK_IDENT, b);
      end else begin
        tok_line = line_no;
        push_tok(TK_PUNCT, b, 1'b1, tok_line);
      end
    endfunction

    function void quoted_byte(logic [7:0] b, tok_kind_e k, logic [7:0] close, bit counts);
      push_tok(k, b, 1'b0, tok_line);
      if (esc_star) esc_star = 1'b0;
      else if (b == CH_BSL) esc_star = 1'b1;
      else if (b == close) mode = LM_IDLE;
      else if (b == CH_NL && counts) bump();
    endfunction

    function void take_byte(logic [7:0] b);
      case (mode)
        LM_PP: begin
          if (b == CH_NL) begin
            if (esc_star) begin
              bump();
              esc_star = 1'b0;
            end else begin
              mode = LM_IDLE;
              between_tokens(b);
            end
          end else begin
            esc_star = (b == CH_BSL);
          end
        end
        LM_LCOM: begin
          if (b == CH_NL) begin
            mode = LM_IDLE;
            between_tokens(b);
          end
        end
        LM_BCOM: begin
          if (held_v) begin
            bump();
            held_v = 1'b0;
            held   = 8'h00;
          end
          if (esc_star && b == CH_SLASH) begin
            mode     = LM_IDLE;
            esc_star = 1'b0;
          end else if (b == CH_NL) begin
            held_v   = 1'b1;
            held     = CH_NL;
            esc_star = 1'b0;
          end else begin
            esc_star = (b == CH_STAR);
          end
        end
        LM_STR: quoted_byte(b, TK_STR, CH_DQ, 1'b1);
        LM_CHR: quoted_byte(b, TK_CHR, CH_SQ, 1'b0);
        LM_NUM: begin
          if (is_alnum(b) || b == CH_DOT || b == CH_SQ) begin
            push_tok(TK_NUM, b, 1'b0, tok_line);
          end else begin
            mode = LM_IDLE;
            between_tokens(b);
          end
        end
        LM_IDENT: begin
          if (is_alnum(b) || b == CH_US) begin
            push_tok(TK_IDENT, b, 1'b0, tok_line);
          end else begin
            mode = LM_IDLE;
            between_tokens(b);
          end
        end
        default: begin
          mode = LM_IDLE;
          between_tokens(b);
        end
      endcase
    endfunction

    // accepted input word: work out the words it must produce
    function void note_input(in_word_t w);
      int unsigned n;
      step_q.delete();
      if (w.byte_present) take_byte(w.src_byte);
      if (w.end_of_source) begin
        if (mode == LM_IDLE && held_v) push_tok(TK_PUNCT, held, 1'b1, tok_line);
        push_tok(TK_EOF, 8'h00, 1'b1, line_no);
        restart();
      end
      n = step_q.size();
      if (n > 0) step_q[n-1].last_of_run = 1'b1;
      expected_q = {expected_q, step_q};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_output(out_word_t got);
      out_word_t want;
      string     diffs;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want  = expected_q.pop_front();
      diffs = "";
      if (got.token_kind !== want.token_kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", got.token_kind, want.token_kind)};
      if (got.text_byte !== want.text_byte)
        diffs = {diffs, $sformatf(" byte %h/%h", got.text_byte, want.text_byte)};
      if (got.first_of_token !== want.first_of_token)
        diffs = {diffs, $sformatf(" first %b/%b", got.first_of_token, want.first_of_token)};
      if (got.token_line !== want.token_line)
        diffs = {diffs, $sformatf(" line %0d/%0d", got.token_line, want.token_line)};
      if (got.last_of_run !== want.last_of_run)
        diffs = {diffs, $sformatf(" last %b/%b", got.last_of_run, want.last_of_run)};
      if (diffs != "") report({"got/want:", diffs});
    endtask
  endclass

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  in_word_t  in_word    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  out_word_t out_word;

  lexer_scoreboard sb;
  logic [7:0]      text_q[$];
  int unsigned     burst_left = 0;
  int unsigned     quiet      = 0;
  bit              hold_req   = 1'b0;

  always #4 clk_i = ~clk_i;

  cpp_source_tokenizer #(
    .LineBits(LINE_BITS_TB)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_output(out_word);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: own stall pattern, re-picked at random from four styles; long hold on request
  initial begin : receive_side
    int unsigned cyc;
    int unsigned style;
    cyc   = 0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        cyc++;
        if (cyc % 64 == 0) style = $urandom_range(0, 3);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= (cyc % 4) != 3;
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  function automatic in_word_t mk_word(logic [7:0] b, logic present, logic last);
    in_word_t w;
    w.src_byte      = b;
    w.byte_present  = present;
    w.end_of_source = last;
    return w;
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_ch(logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  // body of a string or char literal, with escapes and raw newlines
  function automatic void lit_text(logic [7:0] close);
    logic [7:0] c;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: begin
          add_ch(CH_BSL);
          case ($urandom_range(0, 3))
            0: add_ch(close);
            1: add_ch(CH_NL);
            2: add_ch(CH_BSL);
            default: add_ch(8'($urandom_range(32, 126)));
          endcase
        end
        1: add_ch(CH_NL);
        default: begin
          c = 8'($urandom_range(32, 126));
          add_ch((c == close || c == CH_BSL) ? CH_DOT : c);
        end
      endcase
    end
    // now and then left open
    if ($urandom_range(0, 11) != 0) add_ch(close);
  endfunction

  function automatic void add_frag();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0: begin
        add_ch(pick("aAbmzZ_"));
        repeat ($urandom_range(0, 5)) add_ch(pick("az09_QZ"));
      end
      1: begin
        add_ch(pick("0123456789"));
        repeat ($urandom_range(0, 4)) add_ch(pick("0189xXeE.'fA"));
      end
      2: begin
        add_ch(CH_DQ);
        lit_text(CH_DQ);
      end
      3: begin
        add_ch(CH_SQ);
        lit_text(CH_SQ);
      end
      4: begin
        add_ch(CH_SLASH);
        add_ch(CH_SLASH);
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(0, 255));
          add_ch((c == CH_NL) ? CH_SP : c);
        end
        add_ch(CH_NL);
      end
      5: begin
        add_ch(CH_SLASH);
        add_ch(CH_STAR);
        repeat ($urandom_range(0, 6)) add_ch(pick("**/\n a"));
        if ($urandom_range(0, 11) != 0) begin
          add_ch(CH_STAR);
          add_ch(CH_SLASH);
        end
      end
      6: begin
        add_ch(CH_NL);
        if ($urandom_range(0, 1)) add_ch(CH_SP);
        add_ch(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 3))
            0: begin
              add_ch(CH_BSL);
              add_ch(CH_NL);
            end
            1: add_ch(CH_BSL);
            default: add_ch(8'($urandom_range(32, 126)));
          endcase
        end
        add_ch(CH_NL);
      end
      7: begin
        add_ch(CH_COLON);
        add_ch(CH_COLON);
      end
      8: begin
        if ($urandom_range(0, 3) == 0) add_ch(8'($urandom_range(128, 255)));
        else add_ch(pick(";,(){}+-*<>=&|!~%^[].:/?@$`#\\"));
      end
      9: add_ch(pick("\t\n\013\014\015 "));
      10: add_ch(8'($urandom_range(0, 255)));
      default: add_ch(pick(":/"));
    endcase
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic put_word(in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i) in_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) put_word(mk_word(s[i], 1'b1, 1'b0));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned n_src;
    int unsigned target;
    bit          close_with_byte;
    sb = new(LINE_BITS_TB);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directive with continuation, escaped string, char holding a newline,
    // block comment over a line, held ':' flushed by a high byte at the end
    feed_text("#\\\n\n\"\\\"\"'\n'/*\n*/:");
    put_word(mk_word(8'hFF, 1'b1, 1'b1));
    // identifier, scope, number, line comment; empty word; bare close
    feed_text("_9::2//\n");
    put_word(mk_word(8'h00, 1'b0, 1'b0));
    put_word(mk_word(8'h5A, 1'b0, 1'b1));
    wait_drained();

    // newline inside a string, held ':' flushed by a bare close
    feed_text("k\n\"\n\":");
    put_word(mk_word(8'hA5, 1'b0, 1'b1));

    rand_items = 0;
    n_src      = 0;
    while (rand_items < RAND_ITEMS) begin
      n_src++;
      text_q.delete();
      if (n_src == 3) wait_drained();
      if (n_src == 1) begin
        // long output stall while a long identifier keeps coming
        hold_req = 1'b1;
        repeat (16) add_ch(pick("abcdef_xyz"));
      end
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 20);
      while (text_q.size() < target) add_frag();
      close_with_byte = $urandom_range(0, 1);
      foreach (text_q[i]) begin
        if ($urandom_range(0, 15) == 0) put_word(mk_word(8'($urandom), 1'b0, 1'b0));
        put_word(mk_word(text_q[i], 1'b1, close_with_byte && i == text_q.size() - 1));
        rand_items++;
      end
      if (!close_with_byte) begin
        put_word(mk_word(8'($urandom), 1'b0, 1'b1));
        rand_items++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/cst_pkg.sv
src/cst_lex_core.sv
src/cst_res_queue.sv
src/cpp_source_tokenizer.sv
tb/cpp_source_tokenizer_test.sv
